// ----- sv/triangle_sweep_joint_commander_assert.svh -----
// assertion macros for the triangle sweep joint commander
`ifndef TRIANGLE_SWEEP_JOINT_COMMANDER_ASSERT_SVH
`define TRIANGLE_SWEEP_JOINT_COMMANDER_ASSERT_SVH

// same-cycle implication
`define TSJC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsjc assertion failed");

// next-cycle implication
`define TSJC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsjc assertion failed");

`endif

// ----- sv/tsjc_pkg.sv -----
// types and constants shared by the triangle sweep joint commander
package tsjc_pkg;

  localparam int unsigned MaxMotors = 16;
  localparam int unsigned MotorW    = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned PosW      = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic signed [PosW-1:0] FloorLimit = -32'sd58982400;

  localparam logic              RstCaptureCenter = 1'b1;
  localparam logic [29:0]       RstAmplitude     = 30'd65536;
  localparam logic signed [31:0] RstFixedLower   = -32'sd65536;
  localparam logic signed [31:0] RstFixedUpper   = 32'sd65536;
  localparam logic signed [31:0] RstHoldValue    = 32'sd0;
  localparam logic [31:0]       RstPhaseStep     = 32'd21474836;
  localparam logic [4:0]        RstMotorTotal    = 5'd1;
  localparam logic [3:0]        RstTargetMotor   = 4'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPTURE_CENTER = 3'd0,
    CFG_AMPLITUDE      = 3'd1,
    CFG_FIXED_LOWER    = 3'd2,
    CFG_FIXED_UPPER    = 3'd3,
    CFG_HOLD_VALUE     = 3'd4,
    CFG_PHASE_STEP     = 3'd5,
    CFG_MOTOR_TOTAL    = 3'd6,
    CFG_TARGET_MOTOR   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_EMIT  = 2'd2
  } state_e;

  typedef enum logic {
    KIND_FEEDBACK = 1'b0,
    KIND_TICK     = 1'b1
  } kind_e;

  typedef struct packed {
    logic                   kind;
    logic [MotorW-1:0]      motor;
    logic signed [PosW-1:0] position;
    logic                   finite;
    logic                   end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [MotorW-1:0]      motor_id;
    logic signed [PosW-1:0] command_position;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic                   start;
    logic signed [PosW-1:0] bound_a;
    logic signed [PosW-1:0] bound_b;
    logic [31:0]            phase;
  } tri_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [PosW-1:0] sweep;
  } tri_rsp_t;

endpackage

// ----- sv/tsjc_ram.sv -----
// generic single-write, single-read ram with registered read data
module tsjc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tsjc_tri.sv -----
// three-stage triangle wave unit: bound ordering, span multiply, final offset
module tsjc_tri (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsjc_pkg::tri_req_t req_i,
  output tsjc_pkg::tri_rsp_t rsp_o
);

  logic        v1_q, v2_q, v3_q;
  logic signed [31:0] lo_q, hi_q, lo2_q, hi2_q, sweep_q;
  logic [31:0] span_q;
  logic [30:0] ph_q;
  logic        half_q, half2_q;
  logic [62:0] prod_q;

  logic signed [31:0] lo_d, hi_d;
  logic [32:0]        span_w;
  logic [31:0]        off_w;

  always_comb begin
    if (req_i.bound_b < req_i.bound_a) begin
      lo_d = req_i.bound_b;
      hi_d = req_i.bound_a;
    end else begin
      lo_d = req_i.bound_a;
      hi_d = req_i.bound_b;
    end
    span_w = {hi_d[31], hi_d} - {lo_d[31], lo_d};
    off_w  = prod_q[62:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    span_q  <= span_w[31:0];
    ph_q    <= req_i.phase[30:0];
    half_q  <= req_i.phase[31];
    prod_q  <= 63'(span_q) * 63'(ph_q);
    lo2_q   <= lo_q;
    hi2_q   <= hi_q;
    half2_q <= half_q;
    sweep_q <= half2_q ? (hi2_q - $signed(off_w)) : (lo2_q + $signed(off_w));
  end

  assign rsp_o.done  = v3_q;
  assign rsp_o.sweep = sweep_q;

endmodule

// ----- sv/triangle_sweep_joint_commander.sv -----
// top level of the triangle sweep joint commander
//
//  channel  dir  handshake               payload
//  in       in   in_valid_i / in_stall_o  in_data_i  (tsjc_pkg::in_item_t)
//  out      out  out_valid_o / out_stall_i out_data_o (tsjc_pkg::out_item_t)
//  cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// a feedback transaction is one ram write plus valid and capture update
// a tick runs the triangle unit, then count commands, one per cycle while the output
// is not stalled, from the position ram read port, where count is motor_total held
// to 1..16; each command passes the pending stage and the output register, and the
// next input is accepted once the last command has left the pending stage
// an output stall holds the read pipeline; input stays stalled until the tick ends
// reset clears control state and valid bits and loads config defaults; the position ram needs no clearing
module triangle_sweep_joint_commander (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tsjc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tsjc_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tsjc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsjc_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic               capture_center_q;
  logic [29:0]        amplitude_q;
  logic signed [31:0] fixed_lower_q, fixed_upper_q, hold_value_q;
  logic [31:0]        phase_step_q;
  logic [4:0]         motor_total_q;
  logic [3:0]         target_motor_q;

  tsjc_pkg::state_e state_q, state_d;
  logic               captured_q;
  logic [31:0]        phase_q;
  logic signed [31:0] active_lower_q, active_upper_q;
  logic [tsjc_pkg::MaxMotors-1:0] entry_valid_q;
  logic               tri_start_q;

  logic [tsjc_pkg::CountW-1:0] issue_cnt_q;
  logic               pend_q, pend_ok_q, pend_last_q;
  logic [tsjc_pkg::MotorW-1:0] pend_idx_q;
  logic               out_valid_q;
  tsjc_pkg::out_item_t out_data_q;

  logic               accept, fb_accept, tick_accept, tick_run, do_capture;
  logic               out_free, move, issue, emit_done;
  logic [tsjc_pkg::CountW-1:0] count_w;
  logic signed [32:0] cap_lo_w, cap_hi_w;
  logic signed [31:0] rdata_s, cmd_w;
  logic [31:0]        rdata;

  tsjc_pkg::tri_req_t tri_req;
  tsjc_pkg::tri_rsp_t tri_rsp;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_center_q <= tsjc_pkg::RstCaptureCenter;
      amplitude_q      <= tsjc_pkg::RstAmplitude;
      fixed_lower_q    <= tsjc_pkg::RstFixedLower;
      fixed_upper_q    <= tsjc_pkg::RstFixedUpper;
      hold_value_q     <= tsjc_pkg::RstHoldValue;
      phase_step_q     <= tsjc_pkg::RstPhaseStep;
      motor_total_q    <= tsjc_pkg::RstMotorTotal;
      target_motor_q   <= tsjc_pkg::RstTargetMotor;
    end else if (cfg_we_i) begin
      case (tsjc_pkg::cfg_idx_e'(cfg_idx_i))
        tsjc_pkg::CFG_CAPTURE_CENTER: capture_center_q <= cfg_data_i[0];
        tsjc_pkg::CFG_AMPLITUDE:      amplitude_q      <= cfg_data_i[29:0];
        tsjc_pkg::CFG_FIXED_LOWER:    fixed_lower_q    <= cfg_data_i;
        tsjc_pkg::CFG_FIXED_UPPER:    fixed_upper_q    <= cfg_data_i;
        tsjc_pkg::CFG_HOLD_VALUE:     hold_value_q     <= cfg_data_i;
        tsjc_pkg::CFG_PHASE_STEP:     phase_step_q     <= cfg_data_i;
        tsjc_pkg::CFG_MOTOR_TOTAL:    motor_total_q    <= cfg_data_i[4:0];
        tsjc_pkg::CFG_TARGET_MOTOR:   target_motor_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (motor_total_q == 5'd0) begin
      count_w = 5'd1;
    end else if (motor_total_q > 5'(tsjc_pkg::MaxMotors)) begin
      count_w = 5'(tsjc_pkg::MaxMotors);
    end else begin
      count_w = motor_total_q;
    end
  end

  always_comb begin
    cap_lo_w = {in_data_i.position[31], in_data_i.position} - $signed({3'b000, amplitude_q});
    cap_hi_w = {in_data_i.position[31], in_data_i.position} + $signed({3'b000, amplitude_q});
  end

  assign rdata_s  = $signed(rdata);
  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = pend_q && out_free;
  assign issue    = (state_q == tsjc_pkg::ST_EMIT) && (issue_cnt_q < count_w)
                    && (!pend_q || move);
  assign emit_done = (issue_cnt_q == count_w) && !pend_q;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = (state_q != tsjc_pkg::ST_IDLE);
    accept      = in_valid_i && !in_stall_o;
    fb_accept   = accept && (in_data_i.kind == tsjc_pkg::KIND_FEEDBACK);
    tick_accept = accept && (in_data_i.kind == tsjc_pkg::KIND_TICK);
    tick_run    = tick_accept && !(capture_center_q && !captured_q);
    do_capture  = fb_accept && capture_center_q && !captured_q
                  && (in_data_i.motor == target_motor_q) && in_data_i.finite;
    case (state_q)
      tsjc_pkg::ST_IDLE: begin
        if (tick_run) begin
          state_d = tsjc_pkg::ST_SWEEP;
        end
      end
      tsjc_pkg::ST_SWEEP: begin
        if (tri_rsp.done) begin
          state_d = tsjc_pkg::ST_EMIT;
        end
      end
      tsjc_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_d = tsjc_pkg::ST_IDLE;
        end
      end
      default: state_d = tsjc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tsjc_pkg::ST_IDLE;
      captured_q     <= 1'b0;
      phase_q        <= '0;
      active_lower_q <= '0;
      active_upper_q <= '0;
      entry_valid_q  <= '0;
      tri_start_q    <= 1'b0;
      issue_cnt_q    <= '0;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      tri_start_q <= tick_run;
      if (fb_accept) begin
        for (int i = 0; i < tsjc_pkg::MaxMotors; i++) begin
          if (4'(i) == in_data_i.motor) begin
            entry_valid_q[i] <= in_data_i.finite;
          end else if (in_data_i.end_of_message && (4'(i) > in_data_i.motor)) begin
            entry_valid_q[i] <= 1'b0;
          end
        end
      end
      if (do_capture) begin
        active_lower_q <= sat33(cap_lo_w);
        active_upper_q <= sat33(cap_hi_w);
        phase_q        <= '0;
        captured_q     <= 1'b1;
      end else if (tick_run) begin
        phase_q <= phase_q + phase_step_q;
      end
      if (tick_run) begin
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 5'd1;
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (pend_idx_q == target_motor_q) begin
      cmd_w = tri_rsp.sweep;
    end else if (pend_ok_q && (rdata_s > tsjc_pkg::FloorLimit)) begin
      cmd_w = rdata_s;
    end else begin
      cmd_w = hold_value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_idx_q  <= issue_cnt_q[tsjc_pkg::MotorW-1:0];
      pend_ok_q   <= entry_valid_q[issue_cnt_q[tsjc_pkg::MotorW-1:0]];
      pend_last_q <= ((issue_cnt_q + 5'd1) == count_w);
    end
    if (move) begin
      out_data_q.motor_id         <= pend_idx_q;
      out_data_q.command_position <= cmd_w;
      out_data_q.last             <= pend_last_q;
    end
  end

  assign tri_req.start   = tri_start_q;
  assign tri_req.bound_a = capture_center_q ? active_lower_q : fixed_lower_q;
  assign tri_req.bound_b = capture_center_q ? active_upper_q : fixed_upper_q;
  assign tri_req.phase   = phase_q;

  tsjc_tri u_tri (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tri_req),
    .rsp_o  (tri_rsp)
  );

  tsjc_ram #(
    .Width (tsjc_pkg::PosW),
    .Depth (tsjc_pkg::MaxMotors)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (fb_accept),
    .waddr_i (in_data_i.motor),
    .wdata_i (in_data_i.position),
    .re_i    (issue),
    .raddr_i (issue_cnt_q[tsjc_pkg::MotorW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "triangle_sweep_joint_commander_assert.svh"

  `TSJC_ASSERT_NOW(a_tri_done_in_sweep, tri_rsp.done, state_q == tsjc_pkg::ST_SWEEP)
  `TSJC_ASSERT_NOW(a_issue_in_range, issue, (issue_cnt_q < count_w) && in_stall_o)
  `TSJC_ASSERT_NEXT(a_emit_ends, (state_q == tsjc_pkg::ST_EMIT) && emit_done, state_q == tsjc_pkg::ST_IDLE)

endmodule

// ----- bench/tsjc_checker.sv -----
`timescale 1ns / 100ps
// command predictor and comparator for the triangle sweep joint commander
module tsjc_checker
  import tsjc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           commands_o
);

  logic                   capture_center;
  logic [29:0]            amplitude;
  logic signed [PosW-1:0] fixed_lower;
  logic signed [PosW-1:0] fixed_upper;
  logic signed [PosW-1:0] hold_value;
  logic [31:0]            phase_step;
  logic [CountW-1:0]      motor_total;
  logic [MotorW-1:0]      target_motor;

  logic signed [PosW-1:0] joint_pos [MaxMotors];
  logic [MaxMotors-1:0]   joint_ok;
  logic                   captured;
  logic [31:0]            phase;
  logic signed [PosW-1:0] cap_lower;
  logic signed [PosW-1:0] cap_upper;

  out_item_t command_q [$];

  function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -34'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sweep_value(input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi,
                                                    input logic [31:0] ph);
    logic signed [33:0] diff;
    logic [32:0]        span;
    logic [64:0]        prod;
    logic [32:0]        off;
    logic signed [33:0] r;
    diff = 34'(hi) - 34'(lo);
    span = diff[32:0];
    if (!ph[31]) begin
      prod = 65'(span) * 65'(ph);
      off  = prod[63:31];
      r    = 34'(lo) + 34'(off);
    end else begin
      prod = 65'(span) * 65'({1'b0, ph[30:0]});
      off  = prod[63:31];
      r    = 34'(hi) - 34'(off);
    end
    return r[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= 30)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic restore_reset();
    capture_center = RstCaptureCenter;
    amplitude      = RstAmplitude;
    fixed_lower    = RstFixedLower;
    fixed_upper    = RstFixedUpper;
    hold_value     = RstHoldValue;
    phase_step     = RstPhaseStep;
    motor_total    = RstMotorTotal;
    target_motor   = RstTargetMotor;
    joint_ok       = '0;
    captured       = 1'b0;
    phase          = '0;
    cap_lower      = '0;
    cap_upper      = '0;
    command_q.delete();
    fail_count_o   = 0;
    pending_o      = 0;
    commands_o     = 0;
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    case (idx)
      CFG_CAPTURE_CENTER: capture_center = value[0];
      CFG_AMPLITUDE:      amplitude      = value[29:0];
      CFG_FIXED_LOWER:    fixed_lower    = value;
      CFG_FIXED_UPPER:    fixed_upper    = value;
      CFG_HOLD_VALUE:     hold_value     = value;
      CFG_PHASE_STEP:     phase_step     = value;
      CFG_MOTOR_TOTAL:    motor_total    = value[CountW-1:0];
      CFG_TARGET_MOTOR:   target_motor   = value[MotorW-1:0];
      default: ;
    endcase
  endtask

  task automatic absorb_transaction(input in_item_t item);
    int unsigned            count;
    logic signed [PosW-1:0] lo;
    logic signed [PosW-1:0] hi;
    logic signed [PosW-1:0] swap;
    logic signed [PosW-1:0] sweep;
    out_item_t              cmd;
    if (item.kind == KIND_FEEDBACK) begin
      joint_pos[item.motor] = item.position;
      joint_ok[item.motor]  = item.finite;
      if (item.end_of_message)
        for (int i = int'(item.motor) + 1; i < MaxMotors; i++) joint_ok[i] = 1'b0;
      if (capture_center && !captured && item.motor == target_motor && item.finite) begin
        cap_lower = clamp32(34'(item.position) - 34'({1'b0, amplitude}));
        cap_upper = clamp32(34'(item.position) + 34'({1'b0, amplitude}));
        phase     = '0;
        captured  = 1'b1;
      end
      return;
    end
    // waiting for the target's first finite feedback
    if (capture_center && !captured) return;
    phase = phase + phase_step;
    count = 32'(motor_total);
    if (count == 0) count = 1;
    if (count > MaxMotors) count = MaxMotors;
    if (capture_center) begin
      lo = cap_lower;
      hi = cap_upper;
    end else begin
      lo = fixed_lower;
      hi = fixed_upper;
    end
    if (hi < lo) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    sweep = sweep_value(lo, hi, phase);
    for (int unsigned i = 0; i < count; i++) begin
      cmd.motor_id = i[MotorW-1:0];
      if (i == target_motor) cmd.command_position = sweep;
      else if (joint_ok[i] && joint_pos[i] > FloorLimit) cmd.command_position = joint_pos[i];
      else cmd.command_position = hold_value;
      cmd.last = (i + 1 == count);
      command_q.push_back(cmd);
    end
  endtask

  task automatic compare_command(input out_item_t got);
    out_item_t want;
    commands_o++;
    if (command_q.size() == 0) begin
      report_mismatch("command with nothing expected", 32'(got.motor_id),
                      got.command_position);
      return;
    end
    want = command_q.pop_front();
    if (got.motor_id != want.motor_id)
      report_mismatch("motor_id", 32'(got.motor_id), 32'(want.motor_id));
    if (got.command_position !== want.command_position)
      report_mismatch("command_position", got.command_position, want.command_position);
    if (got.last !== want.last)
      report_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_reset();
    end else begin
      if (cfg_we_i) write_register(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (out_valid_i && !out_stall_i) compare_command(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_transaction(in_data_i);
      pending_o = command_q.size();
    end
  end

endmodule

// ----- bench/tb_triangle_sweep_joint_commander.sv -----
`timescale 1ns / 100ps
// stimulus, watchdog and verdict for the triangle sweep joint commander
module tb_triangle_sweep_joint_commander;
  import tsjc_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 160;

  typedef struct {
    logic        capture_center;
    logic [29:0] amplitude;
    logic [31:0] fixed_lower;
    logic [31:0] fixed_upper;
    logic [31:0] hold_value;
    logic [31:0] phase_step;
    logic [4:0]  motor_total;
    logic [3:0]  target_motor;
  } setting_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned commands;
  int unsigned feedback_sent   = 0;
  int unsigned ticks_sent      = 0;
  int unsigned settings_loaded = 0;
  int unsigned quiet_cycles    = 0;
  bit          idle_on         = 1'b1;
  bit          hold_req        = 1'b0;

  triangle_sweep_joint_commander dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  tsjc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .commands_o   (commands)
  );

  initial forever #6 clk = ~clk;

  // command sink: short random stalls plus one long hold on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic setting_t make_setting(input logic cc, input logic [29:0] amp,
                                            input logic [31:0] lower, input logic [31:0] upper,
                                            input logic [31:0] hold, input logic [31:0] step,
                                            input logic [4:0] total, input logic [3:0] target);
    setting_t s;
    s.capture_center = cc;
    s.amplitude      = amp;
    s.fixed_lower    = lower;
    s.fixed_upper    = upper;
    s.hold_value     = hold;
    s.phase_step     = step;
    s.motor_total    = total;
    s.target_motor   = target;
    return s;
  endfunction

  function automatic logic [31:0] rand_position();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      2: return FloorLimit + $urandom_range(0, 4) - 2;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic setting_t rand_setting();
    logic [29:0] amp;
    logic [31:0] step;
    logic [4:0]  total;
    case ($urandom_range(0, 3))
      0: amp = '0;
      1: amp = 30'h3FFF_FFFF;
      default: amp = 30'($urandom_range(0, 32'h0040_0000));
    endcase
    step = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom;
    if (step == 0) step = 1;
    total = $urandom_range(0, 7) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
    return make_setting(1'($urandom_range(0, 1)), amp,
                        $urandom_range(0, 1) ? $urandom : rand_position(),
                        $urandom_range(0, 1) ? $urandom : rand_position(),
                        $urandom, step, total, 4'($urandom_range(0, 15)));
  endfunction

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_setting(input setting_t s);
    write_register(CFG_CAPTURE_CENTER, {31'd0, s.capture_center});
    write_register(CFG_AMPLITUDE,      {2'd0, s.amplitude});
    write_register(CFG_FIXED_LOWER,    s.fixed_lower);
    write_register(CFG_FIXED_UPPER,    s.fixed_upper);
    write_register(CFG_HOLD_VALUE,     s.hold_value);
    write_register(CFG_PHASE_STEP,     s.phase_step);
    write_register(CFG_MOTOR_TOTAL,    {27'd0, s.motor_total});
    write_register(CFG_TARGET_MOTOR,   {28'd0, s.target_motor});
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic push_item(input in_item_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.kind == KIND_TICK) ticks_sent++;
    else feedback_sent++;
  endtask

  task automatic send_feedback(input logic [3:0] motor, input logic [31:0] position,
                               input logic finite, input logic eom);
    in_item_t item;
    item.kind           = KIND_FEEDBACK;
    item.motor          = motor;
    item.position       = position;
    item.finite         = finite;
    item.end_of_message = eom;
    push_item(item);
  endtask

  task automatic send_tick();
    in_item_t item;
    item.kind           = KIND_TICK;
    item.motor          = 4'($urandom);
    item.position       = $urandom;
    item.finite         = 1'($urandom);
    item.end_of_message = 1'($urandom);
    push_item(item);
  endtask

  task automatic send_noise();
    in_item_t item;
    item.kind           = kind_e'($urandom_range(0, 1));
    item.motor          = 4'($urandom);
    item.position       = rand_position();
    item.finite         = 1'($urandom);
    item.end_of_message = 1'($urandom);
    push_item(item);
  endtask

  // one feedback message over a run of motors, then one or two ticks
  task automatic send_message();
    int first_m;
    int last_m;
    first_m = $urandom_range(0, 15);
    last_m  = first_m + $urandom_range(0, 15);
    if (last_m > 15) last_m = 15;
    for (int m = first_m; m <= last_m; m++)
      send_feedback(m[3:0], rand_position(), $urandom_range(0, 7) != 0, m == last_m);
    repeat ($urandom_range(1, 2)) send_tick();
  endtask

  // let the block drain before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing moves until the target reports a finite position
    send_tick();
    send_feedback(4'd0, 32'h7FFF_8000, 1'b0, 1'b0);
    send_feedback(4'd1, 32'h0001_0000, 1'b1, 1'b0);
    send_tick();
    send_feedback(4'd0, 32'h7FFF_8000, 1'b1, 1'b1);
    send_feedback(4'd0, 32'h0000_0000, 1'b1, 1'b0);
    send_tick();
    send_tick();
    wait_quiet();

    // fixed bounds given in reverse order, full range, floor edge on feedback
    load_setting(make_setting(1'b0, 30'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 32'hFFFF_FFFF, 5'd16, 4'd3));
    send_feedback(4'd2, FloorLimit + 1, 1'b1, 1'b0);
    send_feedback(4'd1, FloorLimit, 1'b1, 1'b0);
    send_feedback(4'd15, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_feedback(4'd5, 32'h0000_1234, 1'b0, 1'b0);
    send_feedback(4'd4, 32'h8000_0000, 1'b1, 1'b0);
    send_tick();
    send_feedback(4'd7, 32'h0000_007B, 1'b1, 1'b1);
    send_tick();
    send_tick();
    wait_quiet();

    // zero motor count, zero span, target beyond the emitted count
    load_setting(make_setting(1'b0, 30'd0, 32'h0000_3039, 32'h0000_3039,
                              32'h7FFF_FFFF, 32'd1, 5'd0, 4'd15));
    send_tick();
    send_feedback(4'd0, 32'hFFFF_0000, 1'b1, 1'b1);
    send_tick();
    wait_quiet();

    // count above the motor limit, captured bounds, phase on the half point
    load_setting(make_setting(1'b1, 30'd65536, 32'd0, 32'd0,
                              32'h0000_0000, 32'h8000_0000, 5'd31, 4'd15));
    send_tick();
    send_tick();
    wait_quiet();

    // long output hold with the sender pushing full ticks
    load_setting(make_setting(1'b0, 30'd0, rand_position(), rand_position(),
                              $urandom, $urandom | 32'd1, 5'd16, 4'($urandom_range(0, 15))));
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_tick();
    idle_on  = 1'b1;
    wait_quiet();

    for (int p = 0; p < 5; p++) begin
      load_setting(rand_setting());
      goal = feedback_sent + ticks_sent + 44;
      while (feedback_sent + ticks_sent < goal) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_message();
      end
      wait_quiet();
    end

    // closing stretch without any idling
    load_setting(rand_setting());
    idle_on = 1'b0;
    goal = feedback_sent + ticks_sent + 36;
    while (feedback_sent + ticks_sent < goal) send_message();
    wait_quiet();
    repeat (30) @(posedge clk);

    $display("run covered %0d feedback and %0d tick transactions over %0d register settings",
             feedback_sent, ticks_sent, settings_loaded + 1);
    $display("%0d commands compared, including capture, saturation and a long output hold",
             commands);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- triangle_sweep_joint_commander.f -----
+incdir+sv
sv/tsjc_pkg.sv
sv/tsjc_ram.sv
sv/tsjc_tri.sv
sv/triangle_sweep_joint_commander.sv
bench/tsjc_checker.sv
bench/tb_triangle_sweep_joint_commander.sv
